// ===== src/fifo_counting_semaphore_macros.svh =====
// Assertion helpers for the semaphore block.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef FIFO_COUNTING_SEMAPHORE_MACROS_SVH
`define FIFO_COUNTING_SEMAPHORE_MACROS_SVH
`ifndef SYNTHESIS
`define FCS_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("semaphore check failed");
`define FCS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("semaphore check failed");
`else
`define FCS_ASSERT_SAME(lbl, ante, cons)
`define FCS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== src/fcs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package fcs_pkg;

    // fixed field widths
    localparam int ID_W     = 4;
    localparam int PERMIT_W = 16;
    localparam int WAIT_W   = 5;
    localparam int STATUS_W = 3;
    localparam int DATA_W   = 32;
    localparam int ADDR_W   = 3;

    localparam int QUEUE_DEPTH_DEF = 16;

    localparam logic [PERMIT_W-1:0] PERMIT_MAX = '1;

    // register index decoded from paddr
    localparam logic REG_INIT_PERMITS = 1'b0;

    // opcodes
    localparam logic OP_ACQUIRE = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_GRANTED   = 3'd0,
        ST_QUEUED    = 3'd1,
        ST_FULL      = 3'd2,
        ST_ADDED     = 3'd3,
        ST_SATURATED = 3'd4
    } status_t;

    typedef struct packed {
        logic            opcode;
        logic [ID_W-1:0] requester_id;
    } fcs_in_t;

    typedef struct packed {
        status_t             status;
        logic                grant_valid;
        logic [ID_W-1:0]     granted_id;
        logic [PERMIT_W-1:0] permits_left;
        logic [WAIT_W-1:0]   waiters_left;
    } fcs_out_t;

endpackage
`default_nettype wire

// ===== src/fifo_counting_semaphore.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Counting semaphore with a first-in first-out wait queue.
// Command channel: drive cmd (opcode, requester_id) with start high; the
// transaction is taken at a rising edge where start is high and busy is low.
// Result channel: done is high for exactly one cycle with result valid; the
// receiver must take it then, it cannot stall the block.
// Latency: the cycle after acceptance executes the access (busy high), and
// the result is strobed in the cycle after that.
// No start is taken while busy is high. The wait queue lives in a RAM with
// a registered read; the head entry is read during the accept cycle and used
// in the execute cycle. A new start is taken while done shows.
// Configuration: APB write to address 0 sets initial_permits; the count is
// loaded too when no waiter is queued. Write only while the block is idle.
// Reset: count, queue pointers and fill clear, initial_permits reads zero;
// queue RAM contents are left as they are, only pushed entries are ever used.
module fifo_counting_semaphore
    import fcs_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    // command channel
    input  logic              start,
    output logic              busy,
    input  fcs_in_t           cmd,
    // result channel
    output logic              done,
    output fcs_out_t          result,
    // configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

`include "fifo_counting_semaphore_macros.svh"

    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t              state_reg, state_next;
    fcs_in_t             cmd_reg;
    logic [PERMIT_W-1:0] init_permits_reg;
    logic [PERMIT_W-1:0] permit_reg, permit_next;
    logic [PTR_W-1:0]    head_reg, head_next;
    logic [PTR_W-1:0]    tail_reg, tail_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic                done_reg;
    fcs_out_t            result_reg, result_next;

    logic                accept;
    logic                exec;
    logic                cfg_wr;
    logic                push;
    logic [ID_W-1:0]     head_id;

    assign accept = start && !busy;
    assign exec   = (state_reg == S_EXEC);
    assign busy   = exec;
    assign done   = done_reg;
    assign result = result_reg;

    // config port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[2] == REG_INIT_PERMITS);
    assign prdata = (paddr[2] == REG_INIT_PERMITS) ? DATA_W'(init_permits_reg) : '0;

    // wait queue storage, read address tracks the head
    fcs_ram #(
        .WIDTH (ID_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .wr_en   (push),
        .wr_addr (tail_reg),
        .wr_data (cmd_reg.requester_id),
        .rd_addr (head_reg),
        .rd_data (head_id)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (start) state_next = S_EXEC;
            S_EXEC:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // execute the access
    always_comb
    begin
        permit_next = permit_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        fill_next   = fill_reg;
        push        = 1'b0;
        result_next.status      = ST_GRANTED;
        result_next.grant_valid = 1'b0;
        result_next.granted_id  = '0;
        if (exec)
        begin
            if (cmd_reg.opcode == OP_ACQUIRE)
            begin
                if (permit_reg != '0)
                begin
                    permit_next             = permit_reg - 1'b1;
                    result_next.grant_valid = 1'b1;
                    result_next.granted_id  = cmd_reg.requester_id;
                end
                else if (fill_reg < FILL_MAX)
                begin
                    push      = 1'b1;
                    tail_next = (tail_reg == PTR_LAST) ? '0 : tail_reg + 1'b1;
                    fill_next = fill_reg + 1'b1;
                    result_next.status = ST_QUEUED;
                end
                else
                begin
                    result_next.status = ST_FULL;
                end
            end
            else
            begin
                if (fill_reg == '0)
                begin
                    if (permit_reg == PERMIT_MAX)
                    begin
                        result_next.status = ST_SATURATED;
                    end
                    else
                    begin
                        permit_next        = permit_reg + 1'b1;
                        result_next.status = ST_ADDED;
                    end
                end
                else
                begin
                    // pass the permit straight to the oldest waiter
                    head_next = (head_reg == PTR_LAST) ? '0 : head_reg + 1'b1;
                    fill_next = fill_reg - 1'b1;
                    result_next.grant_valid = 1'b1;
                    result_next.granted_id  = head_id;
                end
            end
        end
        result_next.permits_left = permit_next;
        result_next.waiters_left = WAIT_W'(fill_next);
    end

    // control and counter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            init_permits_reg <= '0;
            permit_reg       <= '0;
            head_reg         <= '0;
            tail_reg         <= '0;
            fill_reg         <= '0;
            done_reg         <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            fill_reg  <= fill_next;
            done_reg  <= exec;
            if (cfg_wr)
            begin
                init_permits_reg <= pwdata[PERMIT_W-1:0];
            end
            if (cfg_wr && fill_reg == '0)
            begin
                permit_reg <= pwdata[PERMIT_W-1:0];
            end
            else
            begin
                permit_reg <= permit_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd;
        end
        if (exec)
        begin
            result_reg <= result_next;
        end
    end

    // checks
    `FCS_ASSERT_NEXT(a_accept_busy, accept, busy)
    `FCS_ASSERT_NEXT(a_exec_done, busy, done && !busy)
    `FCS_ASSERT_SAME(a_fill_bound, 1'b1, fill_reg <= FILL_MAX)
    `FCS_ASSERT_SAME(a_nogrant_id, done && !result.grant_valid, result.granted_id == '0)

endmodule
`default_nettype wire

// ===== src/fcs_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module fcs_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import fcs_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASES      = 9;
    localparam int PHASE_ITEMS = 100;

    localparam logic [ADDR_W-1:0] ADDR_INIT_PERMITS = {REG_INIT_PERMITS, 2'b00};
    // first byte address past the only register
    localparam logic [ADDR_W-1:0] ADDR_SPARE = 3'd4;

    // Expected-result store with its own copy of the semaphore state
    class permit_scoreboard;
        logic [PERMIT_W-1:0] init_permits;
        logic [PERMIT_W-1:0] permit_count;
        logic [ID_W-1:0]     wait_ids [QUEUE_DEPTH_DEF];
        int                  head;
        int                  tail;
        int                  fill;
        fcs_out_t            expected_q [$];
        int                  errors;

        function new();
            init_permits = '0;
            permit_count = '0;
            head         = 0;
            tail         = 0;
            fill         = 0;
            errors       = 0;
            foreach (wait_ids[i]) wait_ids[i] = '0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // register write; count only loads when nobody waits
        function void write_reg(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
            if (addr != ADDR_INIT_PERMITS)
                return;
            init_permits = data[PERMIT_W-1:0];
            if (fill == 0)
                permit_count = init_permits;
        endfunction

        // predict the outcome of one accepted command transaction
        function void note_command(fcs_in_t c);
            fcs_out_t r;
            r = '0;
            if (c.opcode == OP_ACQUIRE)
            begin
                if (permit_count != 0)
                begin
                    permit_count  = permit_count - 1'b1;
                    r.status      = ST_GRANTED;
                    r.grant_valid = 1'b1;
                    r.granted_id  = c.requester_id;
                end
                else if (fill < QUEUE_DEPTH_DEF)
                begin
                    wait_ids[tail] = c.requester_id;
                    tail           = (tail + 1) % QUEUE_DEPTH_DEF;
                    fill++;
                    r.status       = ST_QUEUED;
                end
                else
                begin
                    r.status = ST_FULL;
                end
            end
            else
            begin
                if (fill == 0)
                begin
                    if (permit_count == PERMIT_MAX)
                    begin
                        r.status = ST_SATURATED;
                    end
                    else
                    begin
                        permit_count = permit_count + 1'b1;
                        r.status     = ST_ADDED;
                    end
                end
                else
                begin
                    // permit goes straight to the oldest waiter
                    r.granted_id  = wait_ids[head];
                    head          = (head + 1) % QUEUE_DEPTH_DEF;
                    fill--;
                    r.status      = ST_GRANTED;
                    r.grant_valid = 1'b1;
                end
            end
            r.permits_left = permit_count;
            r.waiters_left = fill[WAIT_W-1:0];
            expected_q.push_back(r);
        endfunction

        function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
            if (act_v !== exp_v)
            begin
                errors++;
                $display("%0t: %s mismatch expected %0h actual %0h",
                         $time, name, exp_v, act_v);
            end
        endfunction

        // check one strobed result against the oldest prediction
        function void check_result(fcs_out_t act);
            fcs_out_t exp_r;
            if (expected_q.size() == 0)
            begin
                errors++;
                $display("%0t: result with nothing expected, actual %p", $time, act);
                return;
            end
            exp_r = expected_q.pop_front();
            compare_field("status", exp_r.status, act.status);
            compare_field("grant_valid", exp_r.grant_valid, act.grant_valid);
            compare_field("granted_id", exp_r.granted_id, act.granted_id);
            compare_field("permits_left", exp_r.permits_left, act.permits_left);
            compare_field("waiters_left", exp_r.waiters_left, act.waiters_left);
        endfunction
    endclass

    logic              clk     = 1'b0;
    logic              rst_n   = 1'b0;
    logic              start   = 1'b0;
    logic              busy;
    fcs_in_t           cmd     = '0;
    logic              done;
    fcs_out_t          result;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [ADDR_W-1:0] paddr   = '0;
    logic [DATA_W-1:0] pwdata  = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    permit_scoreboard sb = new();
    int               cycles     = 0;
    int               burst_left = 0;

    fifo_counting_semaphore uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .cmd     (cmd),
        .done    (done),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 clk = ~clk;

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // monitor: results first, since a new transaction can be taken while done shows
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                sb.check_result(result);
            if (start && !busy)
                sb.note_command(cmd);
        end
    end

    // APB write: setup then access; idle cycle after
    task automatic apb_write(logic [ADDR_W-1:0] a, logic [DATA_W-1:0] d);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= a;
        pwdata  <= d;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        sb.write_reg(a, d);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        pwdata  <= $urandom;
        @(posedge clk);
    endtask

    // APB read of initial_permits, checked against the predicted register
    task automatic apb_read_permits();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_INIT_PERMITS;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata[PERMIT_W-1:0] !== sb.init_permits)
        begin
            sb.errors++;
            $display("%0t: prdata mismatch expected %0h actual %0h",
                     $time, sb.init_permits, prdata[PERMIT_W-1:0]);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // issue one command transaction; bursts with random gaps between them
    task automatic send_command(logic op, logic [ID_W-1:0] id);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                start <= 1'b0;
                cmd   <= $bits(fcs_in_t)'($urandom);
                repeat (gap) @(posedge clk);
            end
        end
        cmd.opcode       <= op;
        cmd.requester_id <= id;
        start            <= 1'b1;
        do @(posedge clk); while (busy);
        burst_left--;
    endtask

    // hold off until every expected result is back
    task automatic wait_idle();
        start      <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic run_phase(int n_items, int acquire_pct);
        for (int i = 0; i < n_items; i++)
        begin
            send_command(($urandom_range(99) < acquire_pct) ? OP_ACQUIRE : OP_RELEASE,
                         ID_W'($urandom_range(15)));
        end
    endtask

    initial
    begin
        logic [PERMIT_W-1:0] phase_perm [PHASES];
        int                  phase_acq  [PHASES];

        phase_perm = '{16'd0, 16'd1, 16'hFFFE, 16'd3, 16'd0, 16'hFFFF, 16'd2,
                       16'($urandom), 16'd40};
        phase_acq  = '{70, 50, 20, 60, 80, 30, 55, 50, 65};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset value, count from zero
        apb_read_permits();
        send_command(OP_RELEASE, 4'd5);
        send_command(OP_ACQUIRE, 4'd3);

        // directed: saturation at the top of the count
        wait_idle();
        apb_write(ADDR_INIT_PERMITS, {16'($urandom), 16'hFFFF});
        apb_read_permits();
        send_command(OP_RELEASE, 4'd0);
        send_command(OP_ACQUIRE, 4'd15);
        send_command(OP_RELEASE, 4'd10);
        send_command(OP_RELEASE, 4'd15);

        // directed: fill the wait queue, then one rejected acquire
        wait_idle();
        apb_write(ADDR_INIT_PERMITS, 32'd0);
        for (int i = 0; i < QUEUE_DEPTH_DEF; i++)
            send_command(OP_ACQUIRE, i[ID_W-1:0]);
        send_command(OP_ACQUIRE, 4'd9);

        // directed: write while waiters queued is stored but not loaded
        wait_idle();
        apb_write(ADDR_INIT_PERMITS, 32'd7);
        apb_read_permits();
        apb_write(ADDR_SPARE, $urandom);
        send_command(OP_RELEASE, 4'd12);
        send_command(OP_RELEASE, 4'd1);

        // random phases, each with its own permit load and acquire mix
        for (int p = 0; p < PHASES; p++)
        begin
            wait_idle();
            apb_write(ADDR_INIT_PERMITS, {16'($urandom), phase_perm[p]});
            if ($urandom_range(2) == 0)
                apb_write(ADDR_SPARE, $urandom);
            apb_read_permits();
            run_phase(PHASE_ITEMS, phase_acq[p]);
        end

        wait_idle();
        repeat (8) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+src
src/fcs_pkg.sv
src/fcs_ram.sv
src/fifo_counting_semaphore.sv
dv/testbench.sv
